>>> rtl/cpcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcn_pkg
// Shared constants, state type and the serial divide step for the circle
// pair contact block.
// ----------------------------------------------------------------------------
package cpcn_pkg;

    localparam int POS_W_DEF = 24;
    localparam int RAD_W     = 16;
    localparam int MAG_W     = RAD_W + 1;
    localparam int SQ_W      = 2 * MAG_W + 1;
    localparam int FRAC_SH   = 16;
    localparam int RS_SH     = 8;
    localparam int ROOT_W    = 26;
    localparam int V_W       = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 1;
    localparam int Q_W       = 15;
    localparam int NUM_W     = ROOT_W + Q_W;
    localparam int NX_SH     = 22;
    localparam int OV_SH     = 6;
    localparam int NORM_W    = 16;
    localparam int OVL_W     = 15;
    localparam int OUT_W     = 2 * NORM_W + OVL_W;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int CNT_W     = $clog2(ROOT_W);

    localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SQRT,
        ST_TEST,
        ST_DIV,
        ST_DONE
    } t_state;

    // one restoring division step: remainder above, quotient bits shift in below
    function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0]  acc,
                                                  input logic [ROOT_W-1:0] den);
        logic [ROOT_W:0] t;
        logic [ROOT_W:0] d;
        logic [ROOT_W:0] diff;
        t    = {acc[NUM_W-1:Q_W], acc[Q_W-1]};
        d    = {1'b0, den};
        diff = t - d;
        if (t >= d) begin
            return {diff[ROOT_W-1:0], acc[Q_W-2:0], 1'b1};
        end else begin
            return {t[ROOT_W-1:0], acc[Q_W-2:0], 1'b0};
        end
    endfunction

endpackage

>>> rtl/circle_pair_contact_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pair_contact_normal
// Narrow-phase circle contact: stores a reference circle and tests candidate
// circles against it, giving the contact normal and overlap in Q1.14.
// ----------------------------------------------------------------------------
// input stream: tuser = op (0 stores the reference circle, 1 tests a candidate),
// tdata = pos_x, pos_y, radius. a reference transfer gives no result and the
// block is ready again on the next cycle. a candidate gives exactly one result.
// output stream: tuser = collided, tdata = normal_x, normal_y, overlap.
// a candidate passes through set-up, bit-serial squaring, a bit-serial root, a
// test, three bit-serial dividers run side by side and formatting into the
// output register. candidates whose centres are far apart on one axis skip
// to the result after set-up; misses and coincident centres skip the dividers.
// one candidate is worked on at a time; the next is taken once the result has
// moved to the output register. a stalled receiver holds the output register,
// the block still takes the next item and only waits at its end if the
// previous result has not yet left.
// reset empties the output register, returns to idle and sets the reference
// circle to centre 0, radius 0.
// ----------------------------------------------------------------------------
module circle_pair_contact_normal #(
    parameter  int POS_WIDTH = cpcn_pkg::POS_W_DEF,
    localparam int S_TDATA_W = ((2 * POS_WIDTH + cpcn_pkg::RAD_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]           i_s_axis_tdata,  // pos_x, pos_y, radius
    input  logic                           i_s_axis_tuser,  // op
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [cpcn_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // normal_x, normal_y, overlap
    output logic                           o_m_axis_tuser   // collided
);

    localparam int MAG_W  = cpcn_pkg::MAG_W;
    localparam int SQ_W   = cpcn_pkg::SQ_W;
    localparam int ROOT_W = cpcn_pkg::ROOT_W;
    localparam int V_W    = cpcn_pkg::V_W;
    localparam int REM_W  = cpcn_pkg::REM_W;
    localparam int Q_W    = cpcn_pkg::Q_W;
    localparam int NUM_W  = cpcn_pkg::NUM_W;
    localparam int NORM_W = cpcn_pkg::NORM_W;
    localparam int OVL_W  = cpcn_pkg::OVL_W;
    localparam int RAD_W  = cpcn_pkg::RAD_W;
    localparam int CNT_W  = cpcn_pkg::CNT_W;
    localparam int PAD_W  = cpcn_pkg::M_TDATA_W - cpcn_pkg::OUT_W;
    localparam int D_W    = POS_WIDTH + 1;

    cpcn_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic signed [POS_WIDTH-1:0] r_ref_x, n_ref_x, r_ref_y, n_ref_y;
    logic [RAD_W-1:0]            r_ref_rad, n_ref_rad;
    logic signed [POS_WIDTH-1:0] r_px, n_px, r_py, n_py;
    logic [RAD_W-1:0]            r_rad, n_rad;
    logic                        r_sx, n_sx, r_sy, n_sy;
    logic [MAG_W-1:0]            r_ax, n_ax, r_ay, n_ay, r_rs, n_rs;
    logic [SQ_W-1:0]             r_ma, n_ma, r_mb, n_mb, r_acc, n_acc;
    logic [MAG_W-1:0]            r_ba, n_ba, r_bb, n_bb;
    logic [V_W-1:0]              r_v, n_v;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [ROOT_W-1:0]           r_root, n_root;
    logic [NUM_W-1:0]            r_qx, n_qx, r_qy, n_qy, r_qo, n_qo;
    logic                        r_hit, n_hit, r_coinc, n_coinc;
    logic                        r_out_valid, n_out_valid;
    logic [cpcn_pkg::M_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic                        r_out_tuser, n_out_tuser;

    logic                        s_fire;
    logic                        out_load;
    logic signed [D_W-1:0]       dx, dy;
    logic [D_W-1:0]              adx, ady, rs_ext;
    logic [MAG_W-1:0]            rs_sum;
    logic                        prep_far;
    logic [SQ_W-1:0]             mul_sum;
    logic [REM_W+1:0]            sq_t, sq_trial, sq_diff;
    logic                        test_beyond, test_zero;
    logic [Q_W-1:0]              qx_c, qy_c, qo;
    logic [NORM_W-1:0]           mx, my, nx_val, ny_val;
    logic [OVL_W-1:0]            ov_val;

    // input unpacking and set-up arithmetic
    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign dx       = D_W'(r_px) - D_W'(r_ref_x);
    assign dy       = D_W'(r_py) - D_W'(r_ref_y);
    assign adx      = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    assign ady      = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    assign rs_sum   = MAG_W'(r_rad) + MAG_W'(r_ref_rad);
    assign rs_ext   = D_W'(rs_sum);
    assign prep_far = (adx >= rs_ext) || (ady >= rs_ext);

    assign mul_sum  = r_acc + (r_ba[0] ? r_ma : '0) + (r_bb[0] ? r_mb : '0);

    assign sq_t     = {r_rem, r_v[V_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_diff  = sq_t - sq_trial;

    assign test_beyond = r_root >= ROOT_W'({r_rs, cpcn_pkg::RS_SH'(0)});
    assign test_zero   = (r_root == '0);

    // result formatting
    assign qx_c   = (r_qx[Q_W-1:0] > cpcn_pkg::ONE_Q14) ? cpcn_pkg::ONE_Q14 : r_qx[Q_W-1:0];
    assign qy_c   = (r_qy[Q_W-1:0] > cpcn_pkg::ONE_Q14) ? cpcn_pkg::ONE_Q14 : r_qy[Q_W-1:0];
    assign qo     = r_qo[Q_W-1:0];
    assign mx     = NORM_W'(qx_c);
    assign my     = NORM_W'(qy_c);
    assign nx_val = (!r_hit || r_coinc) ? '0 : (r_sx ? (~mx + 1'b1) : mx);
    assign ny_val = (!r_hit || r_coinc) ? '0 : (r_sy ? (~my + 1'b1) : my);
    always_comb begin
        if (!r_hit) begin
            ov_val = '0;
        end else if (r_coinc) begin
            ov_val = OVL_W'(cpcn_pkg::ONE_Q14);
        end else if (qo >= cpcn_pkg::ONE_Q14) begin
            ov_val = '0;
        end else begin
            ov_val = OVL_W'(cpcn_pkg::ONE_Q14 - qo);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpcn_pkg::ST_IDLE: begin
                if (s_fire && i_s_axis_tuser) begin
                    n_state = cpcn_pkg::ST_PREP;
                end
            end
            cpcn_pkg::ST_PREP: begin
                n_state = prep_far ? cpcn_pkg::ST_DONE : cpcn_pkg::ST_MUL;
            end
            cpcn_pkg::ST_MUL: begin
                if (r_cnt == '0) begin
                    n_state = cpcn_pkg::ST_SQRT;
                end
            end
            cpcn_pkg::ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = cpcn_pkg::ST_TEST;
                end
            end
            cpcn_pkg::ST_TEST: begin
                n_state = (test_beyond || test_zero) ? cpcn_pkg::ST_DONE : cpcn_pkg::ST_DIV;
            end
            cpcn_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = cpcn_pkg::ST_DONE;
                end
            end
            cpcn_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = cpcn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cpcn_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        o_s_axis_tready = (r_state == cpcn_pkg::ST_IDLE);
        out_load        = (r_state == cpcn_pkg::ST_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    // datapath
    always_comb begin
        n_cnt     = r_cnt;
        n_ref_x   = r_ref_x;
        n_ref_y   = r_ref_y;
        n_ref_rad = r_ref_rad;
        n_px      = r_px;
        n_py      = r_py;
        n_rad     = r_rad;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_rs      = r_rs;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_ba      = r_ba;
        n_bb      = r_bb;
        n_acc     = r_acc;
        n_v       = r_v;
        n_rem     = r_rem;
        n_root    = r_root;
        n_qx      = r_qx;
        n_qy      = r_qy;
        n_qo      = r_qo;
        n_hit     = r_hit;
        n_coinc   = r_coinc;
        case (r_state)
            cpcn_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (i_s_axis_tuser) begin
                        n_px  = i_s_axis_tdata[POS_WIDTH-1:0];
                        n_py  = i_s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
                        n_rad = i_s_axis_tdata[2*POS_WIDTH+RAD_W-1:2*POS_WIDTH];
                    end else begin
                        n_ref_x   = i_s_axis_tdata[POS_WIDTH-1:0];
                        n_ref_y   = i_s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
                        n_ref_rad = i_s_axis_tdata[2*POS_WIDTH+RAD_W-1:2*POS_WIDTH];
                    end
                end
            end
            cpcn_pkg::ST_PREP: begin
                n_sx    = dx[D_W-1];
                n_sy    = dy[D_W-1];
                n_ax    = adx[MAG_W-1:0];
                n_ay    = ady[MAG_W-1:0];
                n_rs    = rs_sum;
                n_ma    = SQ_W'(adx[MAG_W-1:0]);
                n_mb    = SQ_W'(ady[MAG_W-1:0]);
                n_ba    = adx[MAG_W-1:0];
                n_bb    = ady[MAG_W-1:0];
                n_acc   = '0;
                n_cnt   = CNT_W'(MAG_W - 1);
                n_hit   = 1'b0;
                n_coinc = 1'b0;
            end
            cpcn_pkg::ST_MUL: begin
                n_acc = mul_sum;
                n_ma  = r_ma << 1;
                n_mb  = r_mb << 1;
                n_ba  = r_ba >> 1;
                n_bb  = r_bb >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_v    = V_W'(mul_sum) << cpcn_pkg::FRAC_SH;
                    n_rem  = '0;
                    n_root = '0;
                    n_cnt  = CNT_W'(ROOT_W - 1);
                end
            end
            cpcn_pkg::ST_SQRT: begin
                n_v   = r_v << 2;
                n_cnt = r_cnt - 1'b1;
                if (sq_t >= sq_trial) begin
                    n_rem  = REM_W'(sq_diff);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(sq_t);
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            cpcn_pkg::ST_TEST: begin
                n_hit   = !test_beyond;
                n_coinc = test_zero;
                n_qx    = (NUM_W'(r_ax) << cpcn_pkg::NX_SH) + NUM_W'(r_root >> 1);
                n_qy    = (NUM_W'(r_ay) << cpcn_pkg::NX_SH) + NUM_W'(r_root >> 1);
                n_qo    = (NUM_W'(r_root) << cpcn_pkg::OV_SH) + NUM_W'(r_rs >> 1);
                n_cnt   = CNT_W'(Q_W - 1);
            end
            cpcn_pkg::ST_DIV: begin
                n_qx  = cpcn_pkg::div_step(r_qx, r_root);
                n_qy  = cpcn_pkg::div_step(r_qy, r_root);
                n_qo  = cpcn_pkg::div_step(r_qo, ROOT_W'(r_rs));
                n_cnt = r_cnt - 1'b1;
            end
            cpcn_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_tdata = {PAD_W'(0), ov_val, ny_val, nx_val};
            n_out_tuser = r_hit;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpcn_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_ref_rad   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ref_x     <= n_ref_x;
            r_ref_y     <= n_ref_y;
            r_ref_rad   <= n_ref_rad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_px        <= n_px;
        r_py        <= n_py;
        r_rad       <= n_rad;
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_rs        <= n_rs;
        r_ma        <= n_ma;
        r_mb        <= n_mb;
        r_ba        <= n_ba;
        r_bb        <= n_bb;
        r_acc       <= n_acc;
        r_v         <= n_v;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_qx        <= n_qx;
        r_qy        <= n_qy;
        r_qo        <= n_qo;
        r_hit       <= n_hit;
        r_coinc     <= n_coinc;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    // checks
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("miss result carries non-zero fields");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[NORM_W-1:0]) <= 17'sd16384) &&
            ($signed(o_m_axis_tdata[NORM_W-1:0]) >= -17'sd16384) &&
            ($signed(o_m_axis_tdata[2*NORM_W-1:NORM_W]) <= 17'sd16384) &&
            ($signed(o_m_axis_tdata[2*NORM_W-1:NORM_W]) >= -17'sd16384) &&
            (o_m_axis_tdata[2*NORM_W+OVL_W-1:2*NORM_W] <= OVL_W'(cpcn_pkg::ONE_Q14)))
        else $error("normal or overlap out of range");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpcn_pkg::ST_DIV) |->
            (r_qo[NUM_W-1:Q_W] < ROOT_W'(r_rs)) && (r_qx[NUM_W-1:Q_W] < r_root))
        else $error("divider remainder not below divisor");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == cpcn_pkg::ST_DONE))
        else $error("result appeared outside the done state");

endmodule
